### hw/rtl/lca_pkg.sv
// Shared types and constants for the lowest common ancestor engine.
// No dependencies; imported by lca_binary_lifting and lca_checker.
package lca_pkg;

  localparam int NODE_W  = 10;
  localparam int DEPTH_W = 11;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_START,
    ST_LD_LEVEL,
    ST_Q_RDX,
    ST_Q_RDY,
    ST_Q_ORDER,
    ST_LIFT_J,
    ST_LIFT_D,
    ST_EQ,
    ST_CMP_Y,
    ST_CMP,
    ST_FINAL,
    ST_DONE
  } lca_state_t;

endpackage

### hw/rtl/lca_binary_lifting.sv
// Lowest common ancestor engine with a depth memory and a jump table memory.
// Depends on lca_pkg for the state type, field widths and command codes.
//
//   Channel   Signals                                     Direction
//   input     in_valid in_ready in_command in_node_a/b    in
//   result    out_valid out_ready out_ancestor_node       out
//
// A load does one jump table read and write per level; a load of node 0 does neither.
// A query lifts the deeper node, then, unless one node lies above the other, lifts both;
// each level needs two reads through memories with a registered read. After reset the
// depth memory is cleared one entry a cycle, all NODE_COUNT entries, with in_ready low.
// One item is worked at a time; a finished result waits in the output register while
// the next item is accepted, and stalls the engine only while the register still holds
// an earlier result.
module lca_binary_lifting
  import lca_pkg::*;
#(
  parameter int NODE_COUNT  = 1024,
  parameter int LIFT_LEVELS = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_command,
  input  logic [NODE_W-1:0] in_node_a,
  input  logic [NODE_W-1:0] in_node_b,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [NODE_W-1:0] out_ancestor_node
);

  localparam int AW     = $clog2(NODE_COUNT);
  localparam int LW     = $clog2(LIFT_LEVELS);
  localparam int JAW    = AW + LW;
  localparam int JDEPTH = NODE_COUNT * (1 << LW);
  localparam logic [LW-1:0] LAST_LVL = LW'(LIFT_LEVELS - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NODE_COUNT - 1);

  function automatic logic [NODE_W-1:0] node_of(input logic [NODE_W-1:0] n);
    node_of = (int'(n) < NODE_COUNT) ? n : '0;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [NODE_W-1:0] n);
    addr_of = AW'(n);
  endfunction

  lca_state_t state_r, state_nxt;

  logic [NODE_W-1:0]  x_r, x_nxt, y_r, y_nxt, a_r, a_nxt, res_r, res_nxt;
  logic [DEPTH_W-1:0] dsh_r, dsh_nxt;
  logic [LW-1:0]      lvl_r, lvl_nxt;
  logic [AW-1:0]      clr_cnt_r;
  logic               out_valid_r;
  logic [NODE_W-1:0]  out_node_r;

  logic [NODE_W-1:0]  jmem [JDEPTH];
  logic [JAW-1:0]     j_raddr, j_waddr;
  logic               j_we;
  logic [NODE_W-1:0]  j_wdata, jq_r, jfwd_data_r, jd;
  logic               jfwd_r, jzero_r;

  logic [DEPTH_W-1:0] dmem [NODE_COUNT];
  logic [AW-1:0]      d_raddr, d_waddr;
  logic               d_we;
  logic [DEPTH_W-1:0] d_wdata, dq_r;

  logic               in_xfer, out_free;
  logic [NODE_W-1:0]  y_new, x_new;

  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign jd = jzero_r ? '0 : (jfwd_r ? jfwd_data_r : jq_r);

  always_ff @(posedge clk) begin
    if (j_we) begin
      jmem[j_waddr] <= j_wdata;
    end
    jq_r        <= jmem[j_raddr];
    jfwd_r      <= j_we && (j_waddr == j_raddr);
    jfwd_data_r <= j_wdata;
    jzero_r     <= (j_raddr[JAW-1:LW] == '0);
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      dmem[d_waddr] <= d_wdata;
    end
    dq_r <= dmem[d_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:    if (clr_cnt_r == LAST_ADDR) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_command == CMD_QUERY) begin
            state_nxt = ST_Q_RDX;
          end else if (node_of(in_node_a) == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_LD_START;
          end
        end
      end
      ST_LD_START: state_nxt = ST_LD_LEVEL;
      ST_LD_LEVEL: if (lvl_r == LAST_LVL) state_nxt = ST_DONE;
      ST_Q_RDX:    state_nxt = ST_Q_RDY;
      ST_Q_RDY:    state_nxt = ST_Q_ORDER;
      ST_Q_ORDER:  state_nxt = ST_LIFT_J;
      ST_LIFT_J:   state_nxt = ST_LIFT_D;
      ST_LIFT_D:   state_nxt = (lvl_r == '0) ? ST_EQ : ST_LIFT_J;
      ST_EQ:       state_nxt = (x_r == y_r) ? ST_DONE : ST_CMP_Y;
      ST_CMP_Y:    state_nxt = ST_CMP;
      ST_CMP:      state_nxt = (lvl_r == '0) ? ST_FINAL : ST_CMP_Y;
      ST_FINAL:    state_nxt = ST_DONE;
      ST_DONE:     if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    x_nxt    = x_r;
    y_nxt    = y_r;
    a_nxt    = a_r;
    res_nxt  = res_r;
    dsh_nxt  = dsh_r;
    lvl_nxt  = lvl_r;
    j_raddr  = '0;
    j_we     = 1'b0;
    j_waddr  = '0;
    j_wdata  = '0;
    d_raddr  = '0;
    d_we     = 1'b0;
    d_waddr  = '0;
    d_wdata  = '0;
    y_new    = y_r;
    x_new    = x_r;
    unique case (state_r)
      ST_CLEAR: begin
        d_we    = 1'b1;
        d_waddr = clr_cnt_r;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        x_nxt    = node_of(in_node_a);
        y_nxt    = node_of(in_node_b);
        res_nxt  = '0;
      end
      ST_LD_START: begin
        d_raddr = addr_of(y_r);
        j_we    = 1'b1;
        j_waddr = {addr_of(x_r), LW'(0)};
        j_wdata = y_r;
        j_raddr = {addr_of(y_r), LW'(0)};
        lvl_nxt = LW'(1);
      end
      ST_LD_LEVEL: begin
        j_we    = 1'b1;
        j_waddr = {addr_of(x_r), lvl_r};
        j_wdata = jd;
        j_raddr = {addr_of(jd), lvl_r};
        if (lvl_r == LW'(1)) begin
          d_we    = 1'b1;
          d_waddr = addr_of(x_r);
          d_wdata = (dq_r == DEPTH_MAX) ? DEPTH_MAX : DEPTH_W'(dq_r + 1'b1);
        end
        if (lvl_r != LAST_LVL) begin
          lvl_nxt = lvl_r + 1'b1;
        end
      end
      ST_Q_RDX: d_raddr = addr_of(x_r);
      ST_Q_RDY: begin
        d_raddr = addr_of(y_r);
        dsh_nxt = dq_r;
      end
      ST_Q_ORDER: begin
        if (dsh_r > dq_r) begin
          x_nxt   = y_r;
          y_nxt   = x_r;
          dsh_nxt = dq_r;
          y_new   = x_r;
        end
        j_raddr = {addr_of(y_new), LAST_LVL};
        lvl_nxt = LAST_LVL;
      end
      ST_LIFT_J: begin
        a_nxt   = jd;
        d_raddr = addr_of(jd);
      end
      ST_LIFT_D: begin
        if (dq_r >= dsh_r) begin
          y_nxt = a_r;
          y_new = a_r;
        end
        if (lvl_r != '0) begin
          lvl_nxt = lvl_r - 1'b1;
          j_raddr = {addr_of(y_new), lvl_r - 1'b1};
        end
      end
      ST_EQ: begin
        res_nxt = x_r;
        j_raddr = {addr_of(x_r), LAST_LVL};
        lvl_nxt = LAST_LVL;
      end
      ST_CMP_Y: begin
        a_nxt   = jd;
        j_raddr = {addr_of(y_r), lvl_r};
      end
      ST_CMP: begin
        if (a_r != jd) begin
          x_nxt = a_r;
          y_nxt = jd;
          x_new = a_r;
        end
        if (lvl_r != '0) begin
          lvl_nxt = lvl_r - 1'b1;
          j_raddr = {addr_of(x_new), lvl_r - 1'b1};
        end else begin
          j_raddr = {addr_of(x_new), LW'(0)};
        end
      end
      ST_FINAL: res_nxt = jd;
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      lvl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    a_r   <= a_nxt;
    res_r <= res_nxt;
    dsh_r <= dsh_nxt;
    if (state_r == ST_DONE && out_free) begin
      out_node_r <= res_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ancestor_node = out_node_r;

endmodule

### hw/rtl/lca_checker.sv
// Port-level checks for the lowest common ancestor engine, bound to the top.
// Depends on lca_pkg for field widths.
module lca_checker
  import lca_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_command,
  input logic [NODE_W-1:0] in_node_a,
  input logic [NODE_W-1:0] in_node_b,
  input logic              out_valid,
  input logic              out_ready,
  input logic [NODE_W-1:0] out_ancestor_node
);

  // The depth memory is swept after reset, so no transfer is taken right away.
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  // Items are worked one at a time.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready in the cycle after a transfer");

  // A result appears only out of a busy cycle.
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while the engine was idle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_ancestor_node)))
    else $error("stalled result changed");

endmodule

bind lca_binary_lifting lca_checker u_lca_checker (.*);
